[rtl/core/pla_pkg.sv]
// ============================================================================
// pla_pkg
// Shared types, widths and helpers for the per-label average block.
// ============================================================================
package pla_pkg;

  // Field widths and store depth
  localparam int LABELS      = 1024;
  localparam int LABEL_BITS  = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int ADDR_BITS   = $clog2(LABELS);
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  // Operation codes
  localparam logic OP_ACCUM  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Count value at which further samples are dropped
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Sample range limits, at sample and at sum width
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_HI =
    {{(COUNT_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LO = ~SUM_HI;

  // Command transaction
  typedef struct packed {
    logic                          op;
    logic [LABEL_BITS-1:0]         label;
    logic signed [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [COUNT_BITS-1:0]         sample_count;
    logic                          saturated;
  } result_t;

  // One store entry: running sum and sample count
  typedef struct packed {
    logic signed [SUM_BITS-1:0] sum;
    logic [COUNT_BITS-1:0]      count;
  } entry_t;

  // Clamp a signed sum into the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sum(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SUM_HI) begin
      r = SAMPLE_HI;
    end else if (v < SUM_LO) begin
      r = SAMPLE_LO;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/per_label_average.sv]
// ============================================================================
// per_label_average
// Per-label running sum and count with truncated-mean reports (label 0 reports its clamped sum).
// ============================================================================
// After reset the block runs a clearing pass over its 1024-entry store, one
// entry per cycle, and holds busy high until the pass ends. A command is
// taken when start is high and busy is low. An accumulate command reads its
// store entry as it is taken and holds busy while the entry is written back.
// A report of a non-empty label other than 0 runs a restoring divider that
// produces one quotient bit per cycle, after a store read and before a finish
// step, and the result appears in the cycle after the finish step; every
// other report is answered straight after its store read step.
// Each result is shown for exactly one cycle with done high and cannot be
// held off by the receiver.
module per_label_average (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pla_pkg::cmd_t    cmd,
  output logic             done,
  output pla_pkg::result_t result
);
  import pla_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(LABELS - 1);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);
  localparam logic [SUM_BITS-1:0]  QUO_HI    =
    {{(COUNT_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};

  state_t state;

  // Store
  entry_t mem [LABELS];
  entry_t rd_data;
  logic   mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  entry_t mem_wdata;

  // Captured command
  logic                          op_q;
  logic [LABEL_BITS-1:0]         label_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Clearing pass
  logic [ADDR_BITS-1:0] clr_addr;

  // Divider
  logic [COUNT_BITS-1:0] div_cnt;
  logic [COUNT_BITS-1:0] rem;
  logic [SUM_BITS-1:0]   quo;
  logic [STEP_BITS-1:0]  step;
  logic                  neg;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  logic accept;
  logic in_range;
  logic [SUM_BITS-1:0] sum_mag;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = (int'(label_q) < LABELS);
  assign sum_mag  = rd_data.sum[SUM_BITS-1] ? SUM_BITS'(-rd_data.sum)
                                            : SUM_BITS'(rd_data.sum);

  // Store write: clearing pass or accumulate write back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_MOD && op_q == OP_ACCUM && in_range &&
                 rd_data.count != COUNT_MAX) begin
      mem_we          = 1'b1;
      mem_waddr       = label_q[ADDR_BITS-1:0];
      mem_wdata.sum   = rd_data.sum +
                        {{COUNT_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
      mem_wdata.count = rd_data.count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cmd.label[ADDR_BITS-1:0]];
  end

  // Divider step: one quotient bit per cycle
  assign shifted = {rem, quo[SUM_BITS-1]};
  assign diff    = shifted - {1'b0, div_cnt};
  assign fits    = (shifted >= {1'b0, div_cnt});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (clr_addr == ADDR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (op_q == OP_REPORT && in_range && label_q != '0 &&
              rd_data.count != '0) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
            done  <= (op_q == OP_REPORT);
          end
        end
        S_DIV: begin
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Datapath: command capture, divider, result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= cmd.op;
      label_q  <= cmd.label;
      sample_q <= cmd.sample;
    end
    case (state)
      S_MOD: begin
        div_cnt <= rd_data.count;
        rem     <= '0;
        quo     <= sum_mag;
        step    <= '0;
        neg     <= rd_data.sum[SUM_BITS-1];
        if (!in_range) begin
          result <= '0;
        end else begin
          result.sample_count <= rd_data.count;
          result.saturated    <= (rd_data.count == COUNT_MAX);
          if (label_q == '0) begin
            result.average <= clamp_sum(rd_data.sum);
          end else begin
            result.average <= '0;
          end
        end
      end
      S_DIV: begin
        rem  <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        quo  <= {quo[SUM_BITS-2:0], fits};
        step <= step + STEP_BITS'(1);
      end
      S_FIN: begin
        // clamp the truncated quotient into the sample range
        if (neg) begin
          result.average <= (quo > QUO_HI + SUM_BITS'(1)) ? SAMPLE_LO
                                                          : -quo[SAMPLE_BITS-1:0];
        end else begin
          result.average <= (quo > QUO_HI) ? SAMPLE_HI : quo[SAMPLE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state == S_MOD) || $past(state == S_FIN)))
    else $error("result strobe without a finishing step");

  a_accept_mod: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MOD)
    else $error("taken command did not reach the store read step");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < div_cnt))
    else $error("divider remainder out of range");

  a_div_nowrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_FIN) |-> !mem_we)
    else $error("store written during a report");

endmodule
